@@ hw/rtl/lrq_pkg.sv @@
// lrq_pkg: widths, types and constants shared by the look rotation quaternion unit
// no dependencies; imported by every rtl module of the block
package lrq_pkg;

	localparam int IN_WIDTH      = 32;
	localparam int OUT_FRAC_BITS = 14;
	localparam int QOUT_W        = OUT_FRAC_BITS + 2;
	localparam int BASIS_FRAC    = 30;

	// normalizer datapath
	localparam int UV_W   = 64;
	localparam int LANES  = 4;
	localparam int LEAD_W = $clog2(UV_W);
	localparam int NM_W   = 23;
	localparam int SQ_W   = 2 * NM_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int RT_W   = SUM_W / 2;
	localparam int RM_W   = RT_W + 4;
	localparam int QB     = BASIS_FRAC + 1;
	localparam int NUM_W  = NM_W + QB;
	localparam int DR_W   = RT_W + 1;

	// basis and scaled quaternion words
	localparam int BV_W = BASIS_FRAC + 2;
	localparam int UP_W = BV_W + 1;
	localparam int QS_W = BV_W + 3;
	localparam int SB_W = 3 * BV_W + 1;

	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	typedef logic signed [UV_W-1:0] lane_t;
	typedef logic signed [BV_W-1:0] bv_t;
	typedef logic signed [UP_W-1:0] upv_t;
	typedef logic signed [QS_W-1:0] qs_t;

	typedef struct packed {
		logic           ok;
		qs_t [3:0]      q;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qlink_t;

	typedef struct packed {
		logic             v;
		logic             ok;
		logic [LANES-1:0] neg;
		logic [SB_W-1:0]  sb;
	} uvmeta_t;

endpackage

@@ hw/rtl/lrq_uvec.sv @@
// lrq_uvec: pipelined vector normalizer, up to four lanes, one vector per cycle while en is high
// block scaling, bit-per-stage square root and bit-per-stage division; uses lrq_pkg
module lrq_uvec (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      short_frac,
	input  logic                                      in_valid,
	input  lrq_pkg::lane_t [lrq_pkg::LANES-1:0]       in_lane,
	input  logic [lrq_pkg::SB_W-1:0]                  in_sb,
	output logic                                      out_valid,
	output logic                                      out_ok,
	output lrq_pkg::bv_t [lrq_pkg::LANES-1:0]         out_lane,
	output logic [lrq_pkg::SB_W-1:0]                  out_sb
);
	import lrq_pkg::*;

	logic [LANES-1:0]            negv;
	uvmeta_t                     meta_s1, meta_s2, meta_s3, meta_s4;
	logic [LANES-1:0][UV_W-1:0]  mag_s1, mag_s2, shw;
	logic [UV_W-1:0]             orv;
	logic [LEAD_W-1:0]           lead, lead_s2;
	logic [LANES-1:0][NM_W-1:0]  shv, m_s3, m_s4;
	logic [LANES-1:0][SQ_W-1:0]  sq_s4;

	// square root stages
	logic [SUM_W-1:0]            rx_s    [RT_W+1];
	logic [RM_W-1:0]             rrem_s  [RT_W+1];
	logic [RT_W-1:0]             root_s  [RT_W+1];
	logic [LANES-1:0][NM_W-1:0]  rm_s    [RT_W+1];
	uvmeta_t                     rmeta_s [RT_W+1];
	logic [RM_W-1:0]             rsh     [RT_W];
	logic [RM_W-1:0]             trial   [RT_W];
	logic                        rtake   [RT_W];

	// division stages
	logic [NUM_W-1:0]            num     [LANES];
	logic [LANES-1:0][DR_W-1:0]  drem_s  [QB+1];
	logic [LANES-1:0][QB-1:0]    dlow_s  [QB+1];
	logic [LANES-1:0][QB-1:0]    dquo_s  [QB+1];
	logic [RT_W-1:0]             dn_s    [QB+1];
	uvmeta_t                     dmeta_s [QB+1];
	logic [LANES-1:0][DR_W-1:0]  dsh     [QB];
	logic [LANES-1:0]            dtake   [QB];

	logic [QB-1:0]               lim;
	logic [LANES-1:0][QB-1:0]    qc;
	bv_t [LANES-1:0]             fin_s;
	uvmeta_t                     fmeta_s;

	always_comb begin
		orv  = '0;
		lead = '0;
		for (int i = 0; i < LANES; i++) begin
			negv[i] = in_lane[i][UV_W-1];
			orv     = orv | mag_s1[i];
		end
		for (int b = 0; b < UV_W; b++)
			if (orv[b]) lead = LEAD_W'(b);
	end

	// bring the largest magnitude into [2^22, 2^23)
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (lead_s2 >= LEAD_W'(NM_W - 1)) begin
				shw[i] = mag_s2[i] >> (lead_s2 - LEAD_W'(NM_W - 1));
			end else begin
				shw[i] = mag_s2[i] << (LEAD_W'(NM_W - 1) - lead_s2);
			end
			shv[i] = shw[i][NM_W-1:0];
		end
	end

	always_comb begin
		for (int j = 0; j < RT_W; j++) begin
			rsh[j]   = {rrem_s[j][RM_W-3:0], rx_s[j][SUM_W-1 -: 2]};
			trial[j] = RM_W'({root_s[j], 2'b01});
			rtake[j] = rsh[j] >= trial[j];
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (short_frac) begin
				num[i] = (NUM_W'(rm_s[RT_W][i]) << OUT_FRAC_BITS)
					+ NUM_W'(root_s[RT_W] >> 1);
			end else begin
				num[i] = (NUM_W'(rm_s[RT_W][i]) << BASIS_FRAC)
					+ NUM_W'(root_s[RT_W] >> 1);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < QB; j++) begin
			for (int i = 0; i < LANES; i++) begin
				dsh[j][i]   = {drem_s[j][i][DR_W-2:0], dlow_s[j][i][QB-1]};
				dtake[j][i] = dsh[j][i] >= DR_W'(dn_s[j]);
			end
		end
	end

	always_comb begin
		lim = short_frac ? (QB'(1) << OUT_FRAC_BITS) : (QB'(1) << BASIS_FRAC);
		for (int i = 0; i < LANES; i++)
			qc[i] = (dquo_s[QB][i] > lim) ? lim : dquo_s[QB][i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			for (int j = 0; j <= RT_W; j++) rmeta_s[j] <= '0;
			for (int j = 0; j <= QB; j++) dmeta_s[j] <= '0;
			fmeta_s <= '0;
		end else if (en) begin
			meta_s1.v   <= in_valid;
			meta_s1.ok  <= 1'b1;
			meta_s1.neg <= negv;
			meta_s1.sb  <= in_sb;
			meta_s2     <= {meta_s1.v, |orv, meta_s1.neg, meta_s1.sb};
			meta_s3     <= meta_s2;
			meta_s4     <= meta_s3;
			rmeta_s[0]  <= meta_s4;
			for (int j = 0; j < RT_W; j++) rmeta_s[j+1] <= rmeta_s[j];
			dmeta_s[0]  <= rmeta_s[RT_W];
			for (int j = 0; j < QB; j++) dmeta_s[j+1] <= dmeta_s[j];
			fmeta_s     <= dmeta_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				mag_s1[i] <= negv[i] ? UV_W'(-in_lane[i]) : UV_W'(in_lane[i]);
				sq_s4[i]  <= SQ_W'(m_s3[i]) * SQ_W'(m_s3[i]);
			end
			mag_s2  <= mag_s1;
			lead_s2 <= lead;
			m_s3    <= shv;
			m_s4    <= m_s3;

			rx_s[0]   <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1])
				+ SUM_W'(sq_s4[2]) + SUM_W'(sq_s4[3]);
			rrem_s[0] <= '0;
			root_s[0] <= '0;
			rm_s[0]   <= m_s4;
			for (int j = 0; j < RT_W; j++) begin
				rx_s[j+1]   <= rx_s[j] << 2;
				rrem_s[j+1] <= rtake[j] ? (rsh[j] - trial[j]) : rsh[j];
				root_s[j+1] <= {root_s[j][RT_W-2:0], rtake[j]};
				rm_s[j+1]   <= rm_s[j];
			end

			for (int i = 0; i < LANES; i++) begin
				drem_s[0][i] <= DR_W'(num[i][NUM_W-1:QB]);
				dlow_s[0][i] <= num[i][QB-1:0];
				dquo_s[0][i] <= '0;
			end
			dn_s[0] <= root_s[RT_W];
			for (int j = 0; j < QB; j++) begin
				for (int i = 0; i < LANES; i++) begin
					drem_s[j+1][i] <= dtake[j][i] ? (dsh[j][i] - DR_W'(dn_s[j])) : dsh[j][i];
					dlow_s[j+1][i] <= dlow_s[j][i] << 1;
					dquo_s[j+1][i] <= {dquo_s[j][i][QB-2:0], dtake[j][i]};
				end
				dn_s[j+1] <= dn_s[j];
			end

			for (int i = 0; i < LANES; i++) begin
				fin_s[i] <= dmeta_s[QB].neg[i] ? -$signed({1'b0, qc[i]})
					: $signed({1'b0, qc[i]});
			end
		end
	end

	assign out_valid = fmeta_s.v;
	assign out_ok    = fmeta_s.ok;
	assign out_lane  = fin_s;
	assign out_sb    = fmeta_s.sb;

endmodule

@@ hw/rtl/lrq_front.sv @@
// lrq_front: builds the orthonormal basis and picks the conversion branch
// two lrq_uvec normalizers in parallel, cross products, a third lrq_uvec; uses lrq_pkg
module lrq_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0]  fwd_x,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0]  fwd_y,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0]  fwd_z,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0]  up_in_x,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0]  up_in_y,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0]  up_in_z,
	output lrq_pkg::qlink_t                      enq,
	input  logic                                 enq_full
);
	import lrq_pkg::*;

	logic                fen;
	lane_t [LANES-1:0]   fl, ul, rl;
	bv_t [LANES-1:0]     fo, uo, ro;
	logic                fo_v, fo_ok, uo_ok, ro_v, ro_ok;
	logic [SB_W-1:0]     r_sb_in, r_sb;
	bv_t [2:0]           fr;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	lane_t [5:0]         prd_s1, prd_s3;
	lane_t [2:0]         rr_s2, up60_s4;
	bv_t [2:0]           f_s1, f_s2, f_s3, f_s4, f_s5, r_s3, r_s4, r_s5;
	logic                ok_s1, ok_s2, ok_s3, ok_s4, ok_s5;
	upv_t [2:0]          up_s5;
	qent_t               ent_s6;

	logic [2:0][UV_W-1:0] umag, urnd;
	upv_t [2:0]          upr;
	qs_t                 m00, m01, m02, m10, m11, m12, m20, m21, m22, one, tr;
	qs_t [3:0]           qv;

	assign fen      = !(v_s6 && enq_full);
	assign in_stall = !fen;

	always_comb begin
		fl[0] = lane_t'(fwd_x);
		fl[1] = lane_t'(fwd_y);
		fl[2] = lane_t'(fwd_z);
		fl[3] = '0;
		ul[0] = lane_t'(up_in_x);
		ul[1] = lane_t'(up_in_y);
		ul[2] = lane_t'(up_in_z);
		ul[3] = '0;
		rl[0] = rr_s2[0];
		rl[1] = rr_s2[1];
		rl[2] = rr_s2[2];
		rl[3] = '0;
		r_sb_in = {ok_s2, f_s2[2], f_s2[1], f_s2[0]};
		for (int i = 0; i < 3; i++) fr[i] = r_sb[i*BV_W +: BV_W];
	end

	lrq_uvec u_fwd (
		.clk, .arst_n, .en(fen), .short_frac(1'b0),
		.in_valid(in_valid), .in_lane(fl), .in_sb('0),
		.out_valid(fo_v), .out_ok(fo_ok), .out_lane(fo), .out_sb()
	);

	lrq_uvec u_up (
		.clk, .arst_n, .en(fen), .short_frac(1'b0),
		.in_valid(in_valid), .in_lane(ul), .in_sb('0),
		.out_valid(), .out_ok(uo_ok), .out_lane(uo), .out_sb()
	);

	lrq_uvec u_right (
		.clk, .arst_n, .en(fen), .short_frac(1'b0),
		.in_valid(v_s2), .in_lane(rl), .in_sb(r_sb_in),
		.out_valid(ro_v), .out_ok(ro_ok), .out_lane(ro), .out_sb(r_sb)
	);

	// round the f x r products half away from zero back to the basis scale
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			umag[i] = up60_s4[i][UV_W-1] ? UV_W'(-up60_s4[i]) : UV_W'(up60_s4[i]);
			urnd[i] = (umag[i] + (UV_W'(1) << (BASIS_FRAC - 1))) >> BASIS_FRAC;
			upr[i]  = up60_s4[i][UV_W-1] ? -$signed({1'b0, urnd[i][UP_W-2:0]})
				: $signed({1'b0, urnd[i][UP_W-2:0]});
		end
	end

	// branch selection on the basis matrix
	always_comb begin
		m00 = qs_t'($signed(r_s5[0]));
		m01 = qs_t'($signed(r_s5[1]));
		m02 = qs_t'($signed(r_s5[2]));
		m10 = qs_t'($signed(up_s5[0]));
		m11 = qs_t'($signed(up_s5[1]));
		m12 = qs_t'($signed(up_s5[2]));
		m20 = qs_t'($signed(f_s5[0]));
		m21 = qs_t'($signed(f_s5[1]));
		m22 = qs_t'($signed(f_s5[2]));
		one = qs_t'(1) <<< BASIS_FRAC;
		tr  = m00 + m11 + m22;
		if (tr > 0) begin
			qv[0] = m12 - m21;
			qv[1] = m20 - m02;
			qv[2] = m01 - m10;
			qv[3] = tr + one;
		end else if (m00 >= m11 && m00 >= m22) begin
			qv[0] = one + m00 - m11 - m22;
			qv[1] = m01 + m10;
			qv[2] = m02 + m20;
			qv[3] = m12 - m21;
		end else if (m11 > m22) begin
			qv[0] = m10 + m01;
			qv[1] = one + m11 - m00 - m22;
			qv[2] = m21 + m12;
			qv[3] = m20 - m02;
		end else begin
			qv[0] = m20 + m02;
			qv[1] = m21 + m12;
			qv[2] = one + m22 - m00 - m11;
			qv[3] = m01 - m10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (fen) begin
			v_s1 <= fo_v;
			v_s2 <= v_s1;
			v_s3 <= ro_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			// right = up x forward
			prd_s1[0] <= $signed(uo[1]) * $signed(fo[2]);
			prd_s1[1] <= $signed(uo[2]) * $signed(fo[1]);
			prd_s1[2] <= $signed(uo[2]) * $signed(fo[0]);
			prd_s1[3] <= $signed(uo[0]) * $signed(fo[2]);
			prd_s1[4] <= $signed(uo[0]) * $signed(fo[1]);
			prd_s1[5] <= $signed(uo[1]) * $signed(fo[0]);
			f_s1      <= fo[2:0];
			ok_s1     <= fo_ok && uo_ok;

			rr_s2[0] <= prd_s1[0] - prd_s1[1];
			rr_s2[1] <= prd_s1[2] - prd_s1[3];
			rr_s2[2] <= prd_s1[4] - prd_s1[5];
			f_s2     <= f_s1;
			ok_s2    <= ok_s1;

			// up' = forward x right
			prd_s3[0] <= $signed(fr[1]) * $signed(ro[2]);
			prd_s3[1] <= $signed(fr[2]) * $signed(ro[1]);
			prd_s3[2] <= $signed(fr[2]) * $signed(ro[0]);
			prd_s3[3] <= $signed(fr[0]) * $signed(ro[2]);
			prd_s3[4] <= $signed(fr[0]) * $signed(ro[1]);
			prd_s3[5] <= $signed(fr[1]) * $signed(ro[0]);
			f_s3      <= fr;
			r_s3      <= ro[2:0];
			ok_s3     <= r_sb[SB_W-1] && ro_ok;

			up60_s4[0] <= prd_s3[0] - prd_s3[1];
			up60_s4[1] <= prd_s3[2] - prd_s3[3];
			up60_s4[2] <= prd_s3[4] - prd_s3[5];
			f_s4       <= f_s3;
			r_s4       <= r_s3;
			ok_s4      <= ok_s3;

			up_s5 <= upr;
			f_s5  <= f_s4;
			r_s5  <= r_s4;
			ok_s5 <= ok_s4;

			ent_s6.ok <= ok_s5;
			ent_s6.q  <= qv;
		end
	end

	assign enq.valid = v_s6;
	assign enq.ent   = ent_s6;

endmodule

@@ hw/rtl/lrq_fifo.sv @@
// lrq_fifo: short queue of scaled quaternions between the front and the back
// register storage with fill count; uses lrq_pkg
module lrq_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  lrq_pkg::qlink_t  enq,
	output logic             full,
	input  logic             pop,
	output lrq_pkg::qlink_t  deq
);
	import lrq_pkg::*;

	qent_t              mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0]   wp_q, rp_q;
	logic [FQ_AW:0]     cnt_q;
	logic               push, take;

	assign full      = cnt_q == (FQ_AW+1)'(FQ_DEPTH);
	assign push      = enq.valid && !full;
	assign deq.valid = cnt_q != '0;
	assign take      = pop && deq.valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= enq.ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (take) rp_q <= rp_q + 1'b1;
			case ({push, take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign deq.ent = mem_q[rp_q];

endmodule

@@ hw/rtl/lrq_back.sv @@
// lrq_back: normalizes the scaled quaternion and holds the result register
// one lrq_uvec in short-fraction mode; uses lrq_pkg
module lrq_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lrq_pkg::qlink_t                     deq,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lrq_pkg::QOUT_W-1:0]   quat_x,
	output logic signed [lrq_pkg::QOUT_W-1:0]   quat_y,
	output logic signed [lrq_pkg::QOUT_W-1:0]   quat_z,
	output logic signed [lrq_pkg::QOUT_W-1:0]   quat_w,
	output logic                                degenerate
);
	import lrq_pkg::*;

	logic               ben, qo_v, qo_ok, ok;
	lane_t [LANES-1:0]  ql;
	bv_t [LANES-1:0]    qo;
	logic [SB_W-1:0]    qo_sb;
	logic               ov_q, dg_q;
	logic [3:0][QOUT_W-1:0] qt_q;

	assign ben = !(ov_q && out_stall);
	assign pop = ben && deq.valid;

	always_comb begin
		for (int i = 0; i < LANES; i++) ql[i] = lane_t'($signed(deq.ent.q[i]));
	end

	lrq_uvec u_quat (
		.clk, .arst_n, .en(ben), .short_frac(1'b1),
		.in_valid(deq.valid), .in_lane(ql), .in_sb({deq.ent.ok, (SB_W-1)'(0)}),
		.out_valid(qo_v), .out_ok(qo_ok), .out_lane(qo), .out_sb(qo_sb)
	);

	assign ok = qo_sb[SB_W-1] && qo_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ben) begin
			ov_q <= qo_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			for (int i = 0; i < 4; i++) qt_q[i] <= ok ? qo[i][QOUT_W-1:0] : '0;
			dg_q <= !ok;
		end
	end

	assign out_valid  = ov_q;
	assign quat_x     = qt_q[0];
	assign quat_y     = qt_q[1];
	assign quat_z     = qt_q[2];
	assign quat_w     = qt_q[3];
	assign degenerate = dg_q;

endmodule

@@ hw/rtl/look_rotation_quaternion_unit.sv @@
// look_rotation_quaternion_unit: top level of the look rotation to quaternion block
// instantiates lrq_front, lrq_fifo and lrq_back; uses lrq_pkg
//
// takes a forward vector and an up hint (signed q16.16) and returns the unit quaternion
// (signed q1.14, 16384 is one) of the rotation whose rows are right = unit(up x fwd),
// up' = fwd x right and unit(fwd). the matrix is converted through the trace branch or
// the largest diagonal branch, and every branch is normalized. zero forward, zero up,
// forward parallel to up, or a quaternion that cancels out raise degenerate with all
// four components zero. one item is accepted per cycle and one result leaves per cycle
// while neither stall is raised; the path from acceptance to out_valid runs through the
// three chained vector normalizers (one square root bit and one quotient bit per stage),
// the cross product, rounding and branch stages, the queue and the result register.
// the front and back halves each freeze on their own stall; a four-entry queue between
// them keeps input acceptance going while a finished result waits on out_stall.
module look_rotation_quaternion_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0] fwd_x,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0] fwd_y,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0] fwd_z,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0] up_in_x,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0] up_in_y,
	input  logic signed [lrq_pkg::IN_WIDTH-1:0] up_in_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lrq_pkg::QOUT_W-1:0]   quat_x,
	output logic signed [lrq_pkg::QOUT_W-1:0]   quat_y,
	output logic signed [lrq_pkg::QOUT_W-1:0]   quat_z,
	output logic signed [lrq_pkg::QOUT_W-1:0]   quat_w,
	output logic                                degenerate
);
	import lrq_pkg::*;

	// front to queue: scaled quaternion plus basis-valid flag
	qlink_t enq;
	logic   enq_full;
	// queue to back
	qlink_t deq;
	logic   deq_pop;

	// basis construction and branch choice
	lrq_front u_front (
		.clk, .arst_n,
		.in_valid, .in_stall,
		.fwd_x, .fwd_y, .fwd_z,
		.up_in_x, .up_in_y, .up_in_z,
		.enq, .enq_full
	);

	// decouples front freeze from back freeze
	lrq_fifo u_fifo (
		.clk, .arst_n,
		.enq, .full(enq_full),
		.pop(deq_pop), .deq
	);

	// final normalization and result register
	lrq_back u_back (
		.clk, .arst_n,
		.deq, .pop(deq_pop),
		.out_valid, .out_stall,
		.quat_x, .quat_y, .quat_z, .quat_w,
		.degenerate
	);

endmodule

@@ hw/rtl/lrq_chk.sv @@
// lrq_chk: port-level checks of the look rotation quaternion unit
// bound to look_rotation_quaternion_unit; uses lrq_pkg
module lrq_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [lrq_pkg::QOUT_W-1:0]   quat_x,
	input  logic signed [lrq_pkg::QOUT_W-1:0]   quat_y,
	input  logic signed [lrq_pkg::QOUT_W-1:0]   quat_z,
	input  logic signed [lrq_pkg::QOUT_W-1:0]   quat_w,
	input  logic                                degenerate
);
	import lrq_pkg::*;

	localparam logic signed [QOUT_W-1:0] QMAX = QOUT_W'(1) << OUT_FRAC_BITS;
	localparam logic signed [QOUT_W-1:0] QMIN = -QMAX;

	// held result stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(quat_x) && $stable(quat_y)
			&& $stable(quat_z) && $stable(quat_w) && $stable(degenerate))
		else $error("result changed under stall");

	// degenerate results carry a zero quaternion
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0)
		else $error("degenerate result with nonzero quaternion");

	// a normalized quaternion is never all zero
	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> quat_x != 0 || quat_y != 0 || quat_z != 0 || quat_w != 0)
		else $error("valid rotation with zero quaternion");

	// components stay within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_x <= QMAX && quat_x >= QMIN && quat_y <= QMAX && quat_y >= QMIN
			&& quat_z <= QMAX && quat_z >= QMIN && quat_w <= QMAX && quat_w >= QMIN)
		else $error("quaternion component out of range");

endmodule

bind look_rotation_quaternion_unit lrq_chk u_lrq_chk (.*);
